@@ hdl/wse_pkg.sv @@
package wse_pkg;

    // Channel payloads
    typedef struct packed {
        logic signed [31:0] drive_torque;
        logic signed [31:0] brake_torque;
        logic signed [31:0] tire_force;
        logic signed [31:0] forward_velocity;
        logic signed [31:0] side_velocity;
    } wse_in_t;

    typedef struct packed {
        logic signed [31:0] next_wheel_speed;
        logic signed [31:0] slip_ratio;
        logic signed [31:0] lateral_slip;
    } wse_out_t;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Shared divider: remainder/divisor width, quotient bits, step counter
    localparam int DEN_W  = 48;
    localparam int QUO_W  = 32;
    localparam int STEP_W = 6;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctl_t;

    // Partial-product multiplier: |net torque| times inertia*step
    localparam int MAC_A_W = 50;
    localparam int MAC_B_W = 48;
    localparam int ACC_W   = MAC_A_W + MAC_B_W;

    typedef enum logic [1:0] {
        PP_LL,
        PP_LH,
        PP_HL,
        PP_HH
    } pp_sel_t;

    typedef struct packed {
        logic    clear;
        logic    valid;
        pp_sel_t part;
    } mac_ctl_t;

endpackage

@@ hdl/wheel_speed_euler_step.sv @@
// Channel  Signals                              Dir  Payload
// in       in_valid / in_ready / in_data        in   drive, brake, tire force, vx, vy
// out      out_valid / out_ready / out_data     out  next speed, slip ratio, lateral slip
// cfg      cfg_write / cfg_index / cfg_data     in   seven registers, write only
//
// An item runs the slip and lateral divisions in turn on the shared
// one-bit-per-cycle divider (18 steps for slip ratio, 32 for lateral slip).
// A zero slip denominator skips the first division; a zero or overflowing lateral
// division skips the second. A new item is taken only in S_IDLE, after S_OUT.
// Reset clears wheel speed to zero and loads register defaults; no clearing pass.
// A result waiting on out_ready does not stop acceptance of the next item.
module wheel_speed_euler_step (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  wse_pkg::wse_in_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output wse_pkg::wse_out_t                 out_data,
    input  logic                              cfg_write,
    input  logic [wse_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wse_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import wse_pkg::*;

    // Register map
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INV_INERTIA = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FLOOR = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CEIL  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_STANDSTILL  = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_FLOOR   = CFG_IDX_W'(6);

    localparam logic [15:0]        RST_RADIUS      = 16'd19661;
    localparam logic [23:0]        RST_INV_INERTIA = 24'd54613;
    localparam logic [23:0]        RST_TIME_STEP   = 24'd16777;
    localparam logic signed [31:0] RST_SPEED_FLOOR = -32'sd13107200;
    localparam logic signed [31:0] RST_SPEED_CEIL  = 32'sd13107200;
    localparam logic [30:0]        RST_STANDSTILL  = 31'd655;
    localparam logic [30:0]        RST_VEL_FLOOR   = 31'd6554;

    localparam int               SCALE_SH   = 48;
    localparam int               DM_W       = 34;
    localparam logic [DM_W-1:0]  DELTA_CAP  = DM_W'(1) << (DM_W - 1);
    localparam logic [STEP_W-1:0] SLIP_STEPS = STEP_W'(18);
    localparam logic [STEP_W-1:0] LAT_STEPS  = STEP_W'(QUO_W);
    localparam logic [31:0]      SAT_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0]      SAT_MIN    = 32'h8000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_NET,
        S_MUL,
        S_DRAIN,
        S_ROUND,
        S_SUM,
        S_CLAMP,
        S_SDIV,
        S_SWAIT,
        S_LDIV,
        S_LWAIT,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] pp_cnt_reg, pp_cnt_next;
    logic       out_valid_reg;
    logic       can_load;

    // Configuration and wheel state
    logic [15:0]        radius_reg;
    logic [23:0]        inv_inertia_reg;
    logic [23:0]        time_step_reg;
    logic signed [31:0] speed_floor_reg;
    logic signed [31:0] speed_ceil_reg;
    logic [30:0]        band_reg;
    logic [30:0]        vel_floor_reg;
    logic signed [31:0] wheel_speed_reg, wheel_speed_next;

    // Datapath registers
    wse_in_t            item_reg;
    logic signed [48:0] vw_reg, vw_next;
    logic signed [48:0] fr_reg, fr_next;
    logic [47:0]        k_reg, k_next;
    logic signed [32:0] tq_diff_reg, tq_diff_next;
    logic [31:0]        vx_mag_reg, vx_mag_next;
    logic [31:0]        vy_mag_reg, vy_mag_next;
    logic               net_neg_reg;
    logic [49:0]        net_mag_reg, net_mag_next;
    logic               num_neg_reg;
    logic [48:0]        num_mag_reg, num_mag_next;
    logic [47:0]        d_slip_reg, d_slip_next;
    logic [31:0]        d_lat_reg, d_lat_next;
    logic [DM_W-1:0]    dm_reg, dm_next;
    logic signed [35:0] sum_reg, sum_next;
    logic [31:0]        slip_reg, slip_next;
    logic [31:0]        lat_reg, lat_q, lat_sat;
    wse_out_t           out_data_reg;

    // Shared units
    div_ctl_t           div_ctl;
    logic [DEN_W-1:0]   div_rem_init;
    logic [QUO_W-1:0]   div_low_init;
    logic [DEN_W-1:0]   div_divisor;
    logic               div_busy;
    logic [QUO_W-1:0]   div_quo;
    mac_ctl_t           mac_ctl;
    logic [ACC_W-1:0]   mac_acc;

    // Intermediates
    logic signed [50:0] net_full;
    logic [50:0]        net_abs;
    logic signed [49:0] num_full;
    logic [49:0]        num_abs;
    logic [48:0]        vw_abs;
    logic [47:0]        vx32_mag, vf32, d_pick;
    logic [ACC_W:0]     rnd;
    logic [ACC_W-SCALE_SH:0] rnd_q;
    logic signed [35:0] floor_ext, ceil_ext, lo_clip, hi_clip;
    logic [31:0]        clip32, clip_mag;
    logic               crossing, near_zero;
    logic               lat_direct;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign can_load  = !out_valid_reg || out_ready;

    // Operand prep: torque/force products and magnitudes
    always_comb
    begin
        vw_next      = wheel_speed_reg * $signed({1'b0, radius_reg});
        fr_next      = item_reg.tire_force * $signed({1'b0, radius_reg});
        k_next       = 48'(inv_inertia_reg) * 48'(time_step_reg);
        tq_diff_next = 33'(item_reg.drive_torque) - 33'(item_reg.brake_torque);
        vx_mag_next  = item_reg.forward_velocity[31] ?
                       (32'd0 - item_reg.forward_velocity) : item_reg.forward_velocity;
        vy_mag_next  = item_reg.side_velocity[31] ?
                       (32'd0 - item_reg.side_velocity) : item_reg.side_velocity;
    end

    // Net torque in Q.32, slip numerator in Q.32, both denominators
    always_comb
    begin
        net_full     = (51'(tq_diff_reg) <<< 16) - 51'(fr_reg);
        net_abs      = net_full[50] ? (51'd0 - net_full) : net_full;
        net_mag_next = net_abs[49:0];

        num_full     = 50'(vw_reg) - (50'(item_reg.forward_velocity) <<< 16);
        num_abs      = num_full[49] ? (50'd0 - num_full) : num_full;
        num_mag_next = num_abs[48:0];

        vw_abs       = vw_reg[48] ? (49'd0 - vw_reg) : vw_reg;
        vx32_mag     = {vx_mag_reg, 16'd0};
        vf32         = {1'b0, vel_floor_reg, 16'd0};
        d_pick       = (vx32_mag > vw_abs[47:0]) ? vx32_mag : vw_abs[47:0];
        d_slip_next  = (vf32 > d_pick) ? vf32 : d_pick;
        d_lat_next   = ({1'b0, vel_floor_reg} > vx_mag_reg) ? {1'b0, vel_floor_reg} : vx_mag_reg;
    end

    // Round the scaled product to nearest, cap the step size
    always_comb
    begin
        rnd     = {1'b0, mac_acc} + ((ACC_W+1)'(1) << (SCALE_SH - 1));
        rnd_q   = rnd[ACC_W:SCALE_SH];
        dm_next = (rnd_q > (ACC_W-SCALE_SH+1)'(DELTA_CAP)) ? DELTA_CAP : rnd_q[DM_W-1:0];
    end

    // Apply the signed step
    always_comb
    begin
        if (net_neg_reg)
            sum_next = 36'(wheel_speed_reg) - $signed({2'b00, dm_reg});
        else
            sum_next = 36'(wheel_speed_reg) + $signed({2'b00, dm_reg});
    end

    // Clamp to floor then ceiling, snap small sign crossings; a zero time step holds speed
    always_comb
    begin
        floor_ext = 36'(speed_floor_reg);
        ceil_ext  = 36'(speed_ceil_reg);
        lo_clip   = (sum_reg < floor_ext) ? floor_ext : sum_reg;
        hi_clip   = (lo_clip > ceil_ext) ? ceil_ext : lo_clip;
        clip32    = hi_clip[31:0];
        clip_mag  = clip32[31] ? (32'd0 - clip32) : clip32;
        crossing  = (!wheel_speed_reg[31] && (wheel_speed_reg != 32'sd0) && clip32[31]) ||
                    (wheel_speed_reg[31] && !clip32[31] && (clip32 != 32'd0));
        near_zero = clip_mag < {1'b0, band_reg};

        if (time_step_reg == 24'd0)
            wheel_speed_next = wheel_speed_reg;
        else if (crossing && near_zero)
            wheel_speed_next = 32'sd0;
        else
            wheel_speed_next = clip32;
    end

    // Slip results from the divider quotient
    always_comb
    begin
        slip_next  = num_neg_reg ? (32'd0 - div_quo) : div_quo;
        lat_direct = (d_lat_reg == 32'd0) || ({16'd0, vy_mag_reg[31:16]} >= d_lat_reg);

        if (item_reg.side_velocity == 32'sd0)
            lat_sat = 32'd0;
        else if (item_reg.side_velocity[31])
            lat_sat = SAT_MIN;
        else
            lat_sat = SAT_MAX;

        if (item_reg.side_velocity[31])
            lat_q = (div_quo[31] && (div_quo[30:0] != 31'd0)) ? SAT_MIN : (32'd0 - div_quo);
        else
            lat_q = div_quo[31] ? SAT_MAX : div_quo;
    end

    // Divider commands; the divisor is held for the whole division
    always_comb
    begin
        div_ctl.start = 1'b0;
        div_ctl.steps = SLIP_STEPS;
        div_rem_init  = 48'(num_mag_reg >> 2);
        div_low_init  = {num_mag_reg[1:0], 30'd0};
        div_divisor   = d_slip_reg;
        if (state_reg == S_SDIV)
        begin
            div_ctl.start = (d_slip_reg != 48'd0);
        end
        else if ((state_reg == S_LDIV) || (state_reg == S_LWAIT))
        begin
            div_ctl.start = (state_reg == S_LDIV) && !lat_direct;
            div_ctl.steps = LAT_STEPS;
            div_rem_init  = 48'(vy_mag_reg[31:16]);
            div_low_init  = {vy_mag_reg[15:0], 16'd0};
            div_divisor   = 48'(d_lat_reg);
        end
    end

    // Multiplier commands
    always_comb
    begin
        mac_ctl.clear = (state_reg == S_NET);
        mac_ctl.valid = (state_reg == S_MUL);
        mac_ctl.part  = pp_sel_t'(pp_cnt_reg);
    end

    // Sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        pp_cnt_next = pp_cnt_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_PREP;
            S_PREP:
                state_next = S_NET;
            S_NET:
            begin
                pp_cnt_next = '0;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                pp_cnt_next = pp_cnt_reg + 2'd1;
                if (pp_sel_t'(pp_cnt_reg) == PP_HH)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
                state_next = S_ROUND;
            S_ROUND:
                state_next = S_SUM;
            S_SUM:
                state_next = S_CLAMP;
            S_CLAMP:
                state_next = S_SDIV;
            S_SDIV:
                state_next = (d_slip_reg != 48'd0) ? S_SWAIT : S_LDIV;
            S_SWAIT:
                if (!div_busy)
                    state_next = S_LDIV;
            S_LDIV:
                state_next = lat_direct ? S_OUT : S_LWAIT;
            S_LWAIT:
                if (!div_busy)
                    state_next = S_OUT;
            S_OUT:
                if (can_load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Sequencer state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pp_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pp_cnt_reg <= pp_cnt_next;
            if ((state_reg == S_OUT) && can_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Configuration registers and wheel speed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg      <= RST_RADIUS;
            inv_inertia_reg <= RST_INV_INERTIA;
            time_step_reg   <= RST_TIME_STEP;
            speed_floor_reg <= RST_SPEED_FLOOR;
            speed_ceil_reg  <= RST_SPEED_CEIL;
            band_reg        <= RST_STANDSTILL;
            vel_floor_reg   <= RST_VEL_FLOOR;
            wheel_speed_reg <= 32'sd0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_RADIUS:      radius_reg      <= cfg_data[15:0];
                    CFG_INV_INERTIA: inv_inertia_reg <= cfg_data[23:0];
                    CFG_TIME_STEP:   time_step_reg   <= cfg_data[23:0];
                    CFG_SPEED_FLOOR: speed_floor_reg <= cfg_data;
                    CFG_SPEED_CEIL:  speed_ceil_reg  <= cfg_data;
                    CFG_STANDSTILL:  band_reg        <= cfg_data[30:0];
                    CFG_VEL_FLOOR:   vel_floor_reg   <= cfg_data[30:0];
                    default:         ;
                endcase
            end
            if (state_reg == S_CLAMP)
                wheel_speed_reg <= wheel_speed_next;
        end
    end

    // Datapath registers, loaded by sequencer state
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_data;
        if (state_reg == S_PREP)
        begin
            vw_reg      <= vw_next;
            fr_reg      <= fr_next;
            k_reg       <= k_next;
            tq_diff_reg <= tq_diff_next;
            vx_mag_reg  <= vx_mag_next;
            vy_mag_reg  <= vy_mag_next;
        end
        if (state_reg == S_NET)
        begin
            net_neg_reg <= net_full[50];
            net_mag_reg <= net_mag_next;
            num_neg_reg <= num_full[49];
            num_mag_reg <= num_mag_next;
            d_slip_reg  <= d_slip_next;
            d_lat_reg   <= d_lat_next;
        end
        if (state_reg == S_ROUND)
            dm_reg <= dm_next;
        if (state_reg == S_SUM)
            sum_reg <= sum_next;
        if ((state_reg == S_SDIV) && (d_slip_reg == 48'd0))
            slip_reg <= 32'd0;
        if ((state_reg == S_SWAIT) && !div_busy)
            slip_reg <= slip_next;
        if ((state_reg == S_LDIV) && lat_direct)
            lat_reg <= lat_sat;
        if ((state_reg == S_LWAIT) && !div_busy)
            lat_reg <= lat_q;
        if ((state_reg == S_OUT) && can_load)
        begin
            out_data_reg.next_wheel_speed <= wheel_speed_reg;
            out_data_reg.slip_ratio       <= slip_reg;
            out_data_reg.lateral_slip     <= lat_reg;
        end
    end

    wse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .rem_init (div_rem_init),
        .low_init (div_low_init),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    wse_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a_mag (net_mag_reg),
        .b_val (k_reg),
        .acc   (mac_acc)
    );

endmodule

@@ hdl/wse_div.sv @@
module wse_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wse_pkg::div_ctl_t            ctl,
    input  logic [wse_pkg::DEN_W-1:0]    rem_init,
    input  logic [wse_pkg::QUO_W-1:0]    low_init,
    input  logic [wse_pkg::DEN_W-1:0]    divisor,
    output logic                         busy,
    output logic [wse_pkg::QUO_W-1:0]    quotient
);
    import wse_pkg::*;

    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  low_reg, low_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W+1:0]  diff;
    logic              fits;

    // One restoring step: shift in the next dividend bit, try to subtract
    always_comb
    begin
        trial = {rem_reg, low_reg[QUO_W-1]};
        diff  = {1'b0, trial} - {2'b00, divisor};
        fits  = !diff[DEN_W+1];

        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;

        if (ctl.start)
        begin
            rem_next  = rem_init;
            low_next  = low_init;
            quo_next  = '0;
            cnt_next  = ctl.steps;
            busy_next = (ctl.steps != '0);
        end
        else if (busy_reg)
        begin
            // remainder stays below divisor, so it fits DEN_W bits either way
            rem_next  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_next  = {low_reg[QUO_W-2:0], 1'b0};
            quo_next  = {quo_reg[QUO_W-2:0], fits};
            cnt_next  = cnt_reg - STEP_W'(1);
            busy_next = (cnt_reg != STEP_W'(1));
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

@@ hdl/wse_mac.sv @@
module wse_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wse_pkg::mac_ctl_t             ctl,
    input  logic [wse_pkg::MAC_A_W-1:0]   a_mag,
    input  logic [wse_pkg::MAC_B_W-1:0]   b_val,
    output logic [wse_pkg::ACC_W-1:0]     acc
);
    import wse_pkg::*;

    localparam int A_HALF = MAC_A_W / 2;
    localparam int B_HALF = MAC_B_W / 2;
    localparam int PROD_W = A_HALF + B_HALF;

    logic [A_HALF-1:0] op_a;
    logic [B_HALF-1:0] op_b;
    logic [PROD_W-1:0] prod_next, prod_reg;
    pp_sel_t           part_reg;
    logic              pvalid_reg;
    logic [ACC_W-1:0]  addend;
    logic [ACC_W-1:0]  acc_reg;

    // Operand halves for the requested partial product
    always_comb
    begin
        case (ctl.part) inside
            PP_HL, PP_HH: op_a = a_mag[MAC_A_W-1:A_HALF];
            default:      op_a = a_mag[A_HALF-1:0];
        endcase
        case (ctl.part) inside
            PP_LH, PP_HH: op_b = b_val[MAC_B_W-1:B_HALF];
            default:      op_b = b_val[B_HALF-1:0];
        endcase
    end

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    // Align the registered product to its weight
    always_comb
    begin
        unique case (part_reg)
            PP_LL:   addend = ACC_W'(prod_reg);
            PP_LH:   addend = ACC_W'(prod_reg) << B_HALF;
            PP_HL:   addend = ACC_W'(prod_reg) << A_HALF;
            PP_HH:   addend = ACC_W'(prod_reg) << (A_HALF + B_HALF);
            default: addend = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pvalid_reg <= 1'b0;
        else
            pvalid_reg <= ctl.valid;
    end

    // Product register; the registered product is accumulated in the following cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        part_reg <= ctl.part;
        if (ctl.clear)
            acc_reg <= '0;
        else if (pvalid_reg)
            acc_reg <= acc_reg + addend;
    end

    assign acc = acc_reg;

endmodule

@@ hdl/wse_checker.sv @@
module wse_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input wse_pkg::wse_out_t  out_data
);
    import wse_pkg::*;

    logic       acc_in, acc_out;
    logic [1:0] pend_reg, pend_next;

    // Items accepted but not yet delivered
    assign acc_in  = in_valid && in_ready;
    assign acc_out = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (acc_in && !acc_out)
            pend_next = pend_reg + 2'd1;
        else if (!acc_in && acc_out)
            pend_next = pend_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    // Busy right after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        acc_in |=> !in_ready)
        else $error("in_ready still high the cycle after an item was taken");

    // No result can appear the cycle after an item is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_in && !out_valid) |=> !out_valid)
        else $error("result appeared one cycle after acceptance");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result dropped or changed");

    // Every delivered result belongs to an accepted item
    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        acc_out |-> (pend_reg != 2'd0))
        else $error("result delivered with no item outstanding");

    // At most one finished item waits while a new one is taken
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        acc_in |-> (pend_reg <= 2'd1))
        else $error("item taken with two items outstanding");

endmodule

bind wheel_speed_euler_step wse_checker u_wse_checker (.*);

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import wse_pkg::*;

    // Register map of the configuration port
    typedef enum logic [2:0] {
        REG_WHEEL_RADIUS,
        REG_INV_INERTIA,
        REG_TIME_STEP,
        REG_SPEED_FLOOR,
        REG_SPEED_CEILING,
        REG_STANDSTILL_BAND,
        REG_VELOCITY_FLOOR
    } cfg_reg_t;

    localparam logic [31:0] W_MAX          = 32'h7FFF_FFFF;
    localparam logic [31:0] W_MIN          = 32'h8000_0000;
    localparam longint      S32_MAX        = 64'sh0000_0000_7FFF_FFFF;
    localparam longint      S32_MIN        = -64'sh0000_0000_8000_0000;
    localparam longint      DELTA_LIMIT    = 64'sh0000_0002_0000_0000;
    localparam int          WATCHDOG_LIMIT = 20000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    wse_in_t          in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    wse_out_t         out_data;
    logic             cfg_write = 1'b0;
    logic [2:0]       cfg_index = '0;
    logic [31:0]      cfg_data = '0;

    // Shadow registers and wheel state of the predictor
    longint cur_radius  = 19661;
    longint cur_inv     = 54613;
    longint cur_dt      = 16777;
    longint cur_floor   = -13107200;
    longint cur_ceiling = 13107200;
    longint cur_band    = 655;
    longint cur_vfloor  = 6554;
    longint wheel_speed = 0;

    wse_in_t  steps_to_send[$];
    wse_out_t results_due[$];

    logic        item_taken = 1'b0;
    bit          calm = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int          idle_cycles = 0;
    int          mismatch_count = 0;

    wheel_speed_euler_step DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint sat32(longint v);
        if (v > S32_MAX)
            return S32_MAX;
        if (v < S32_MIN)
            return S32_MIN;
        return v;
    endfunction

    // One integration step: slips from the old speed, then the Euler update
    function automatic wse_out_t euler_step(wse_in_t s);
        longint       td, tb, f, vx, vy, w;
        longint       vw, vx32, num, den, q, net, dm, nxt, slip, lat;
        logic [95:0]  num96, den96;
        logic [127:0] prod;
        wse_out_t     r;

        td = $signed(s.drive_torque);
        tb = $signed(s.brake_torque);
        f  = $signed(s.tire_force);
        vx = $signed(s.forward_velocity);
        vy = $signed(s.side_velocity);
        w  = wheel_speed;

        // longitudinal slip, Q.32 operands
        vw   = w * cur_radius;
        vx32 = vx * 65536;
        num  = vw - vx32;
        den  = mag(vx32);
        if (mag(vw) > den)
            den = mag(vw);
        if (cur_vfloor * 65536 > den)
            den = cur_vfloor * 65536;
        if (den == 0)
            slip = 0;
        else
        begin
            num96 = 96'(mag(num)) << 16;
            den96 = 96'(den);
            q     = longint'(num96 / den96);
            slip  = sat32((num < 0) ? -q : q);
        end

        // lateral slip, Q16.16 operands
        den = mag(vx);
        if (cur_vfloor > den)
            den = cur_vfloor;
        if (den == 0)
            lat = (vy > 0) ? S32_MAX : ((vy < 0) ? S32_MIN : 0);
        else
        begin
            q   = (mag(vy) << 16) / den;
            lat = sat32((vy < 0) ? -q : q);
        end

        // speed update; a zero step holds the speed untouched
        if (cur_dt == 0)
            nxt = w;
        else
        begin
            net  = td * 65536 - tb * 65536 - f * cur_radius;
            prod = 128'(mag(net));
            prod = prod * 128'(cur_inv * cur_dt) + (128'd1 << 47);
            prod = prod >> 48;
            dm   = (prod > 128'(DELTA_LIMIT)) ? DELTA_LIMIT : longint'(prod[63:0]);
            nxt  = w + ((net < 0) ? -dm : dm);
            if (nxt < cur_floor)
                nxt = cur_floor;
            if (nxt > cur_ceiling)
                nxt = cur_ceiling;
            // small sign crossing snaps to standstill
            if (((w > 0 && nxt < 0) || (w < 0 && nxt > 0)) && mag(nxt) < cur_band)
                nxt = 0;
        end
        wheel_speed = nxt;

        r.next_wheel_speed = nxt[31:0];
        r.slip_ratio       = slip[31:0];
        r.lateral_slip     = lat[31:0];
        return r;
    endfunction

    // Mostly short gaps, some medium, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 80)
            return $urandom_range(1, 4);
        if (r < 96)
            return $urandom_range(5, 70);
        return $urandom_range(100, 300);
    endfunction

    // Field value spread over all magnitudes, with extremes and raw noise
    function automatic logic [31:0] rand_word();
        int unsigned r;
        int unsigned k;
        logic [31:0] v;
        r = $urandom_range(0, 15);
        if (r == 0)
        begin
            case ($urandom_range(0, 4))
                0: v = W_MAX;
                1: v = W_MIN;
                2: v = '0;
                3: v = '1;
                default: v = 32'd1;
            endcase
        end
        else if (r < 4)
            v = $urandom();
        else
        begin
            k = $urandom_range(1, 31);
            v = $urandom() >> (32 - k);
            if ($urandom_range(0, 1) == 1)
                v = -v;
        end
        return v;
    endfunction

    task automatic push_item(logic [31:0] td, logic [31:0] tb, logic [31:0] f,
                             logic [31:0] vx, logic [31:0] vy);
        wse_in_t it;
        it.drive_torque     = td;
        it.brake_torque     = tb;
        it.tire_force       = f;
        it.forward_velocity = vx;
        it.side_velocity    = vy;
        steps_to_send.push_back(it);
    endtask

    task automatic push_random(int n, bit still_vx);
        logic [31:0] vx;
        for (int i = 0; i < n; i++)
        begin
            vx = (still_vx && $urandom_range(0, 1) == 1) ? 32'd0 : rand_word();
            push_item(rand_word(), rand_word(), rand_word(), vx, rand_word());
        end
    endtask

    // Write one register and mirror it in the shadow copy
    task automatic write_reg(cfg_reg_t idx, longint val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[31:0];
        case (idx)
            REG_WHEEL_RADIUS:    cur_radius  = val & 64'hFFFF;
            REG_INV_INERTIA:     cur_inv     = val & 64'hFF_FFFF;
            REG_TIME_STEP:       cur_dt      = val & 64'hFF_FFFF;
            REG_SPEED_FLOOR:     cur_floor   = $signed(val[31:0]);
            REG_SPEED_CEILING:   cur_ceiling = $signed(val[31:0]);
            REG_STANDSTILL_BAND: cur_band    = val & 64'h7FFF_FFFF;
            REG_VELOCITY_FLOOR:  cur_vfloor  = val & 64'h7FFF_FFFF;
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_config(longint radius, longint inv, longint dt, longint lo,
                              longint hi, longint band, longint vfloor);
        write_reg(REG_WHEEL_RADIUS, radius);
        write_reg(REG_INV_INERTIA, inv);
        write_reg(REG_TIME_STEP, dt);
        write_reg(REG_SPEED_FLOOR, lo);
        write_reg(REG_SPEED_CEILING, hi);
        write_reg(REG_STANDSTILL_BAND, band);
        write_reg(REG_VELOCITY_FLOOR, vfloor);
    endtask

    // Hold off until every queued item is sent and every result is back
    task automatic wait_idle();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (steps_to_send.size() != 0 || in_valid || results_due.size() != 0);
    endtask

    // Item driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || item_taken)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (steps_to_send.size() != 0)
                begin
                    in_data  <= steps_to_send.pop_front();
                    in_valid <= 1'b1;
                    gap_left <= calm ? 0 : pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result receiver stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left != 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left <= pick_gap();
            end
        end
    end

    // Monitor: check results, predict accepted items, watchdog
    always @(posedge clk)
    begin
        wse_out_t want;
        item_taken <= in_valid && in_ready;

        if (rst_n && out_valid && out_ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("result with no item outstanding");
                mismatch_count++;
            end
            else
            begin
                want = results_due.pop_front();
                if (out_data.next_wheel_speed !== want.next_wheel_speed)
                begin
                    $error("next_wheel_speed: expected %0d, actual %0d",
                           want.next_wheel_speed, out_data.next_wheel_speed);
                    mismatch_count++;
                end
                if (out_data.slip_ratio !== want.slip_ratio)
                begin
                    $error("slip_ratio: expected %0d, actual %0d",
                           want.slip_ratio, out_data.slip_ratio);
                    mismatch_count++;
                end
                if (out_data.lateral_slip !== want.lateral_slip)
                begin
                    $error("lateral_slip: expected %0d, actual %0d",
                           want.lateral_slip, out_data.lateral_slip);
                    mismatch_count++;
                end
            end
        end

        if (rst_n && in_valid && in_ready)
            results_due.push_back(euler_step(in_data));

        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        longint a, b, v_inv, v_dt, v_band, v_vf;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // defaults: field extremes and zero velocities
        push_item(0, 0, 0, 0, 0);
        push_item(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX);
        push_item(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN);
        push_item(W_MAX, W_MIN, W_MIN, W_MIN, W_MAX);
        push_item(W_MIN, W_MAX, W_MAX, W_MAX, W_MIN);
        push_item(0, 0, 0, 0, W_MAX);
        push_item(0, 0, 0, 0, W_MIN);
        push_item(0, 0, 0, 1, W_MAX);
        push_item(0, 0, 0, -1, W_MIN);
        push_item(256, 0, 0, 65536, 65536);
        push_item(0, 256, 0, -65536, -32768);
        push_item(0, 0, 256, 32'h4000_0000, 1);
        push_item(-1, 1, -1, 5, -5);
        push_item(25600, 0, 0, 0, 0);
        push_random(300, 1'b0);
        wait_idle();

        // gains, ceiling and velocity floor at top values, floor at its lowest, back-to-back traffic
        calm = 1'b1;
        set_config(65535, 24'hFF_FFFF, 24'hFF_FFFF, S32_MIN, S32_MAX, 0, 31'h7FFF_FFFF);
        push_random(150, 1'b0);
        wait_idle();

        // smallest gains, floor equal to ceiling
        calm = 1'b0;
        set_config(1, 1, 1, 12345, 12345, 31'h7FFF_FFFF, 0);
        push_random(100, 1'b0);
        wait_idle();

        // floor above ceiling: result lands on the ceiling
        set_config(19661, 54613, 16777, 1000000, -1000000, 655, 6554);
        push_random(60, 1'b0);
        wait_idle();

        // zero step holds the speed
        set_config(30000, 80000, 0, -13107200, 13107200, 655, 6554);
        push_random(100, 1'b0);
        wait_idle();

        // pinned at standstill with no velocity floor: zero slip denominators
        set_config(19661, 54613, 16777, 0, 0, 655, 0);
        push_item(0, 0, 0, 0, 0);
        push_item(0, 0, 0, 0, 5);
        push_item(0, 0, 0, 0, -5);
        push_item(0, 0, 0, 0, W_MAX);
        push_item(0, 0, 0, 0, W_MIN);
        push_random(60, 1'b1);
        wait_idle();

        // unit gain so that delta equals the net torque word: sign crossings
        set_config(65536 - 1, 65536, 65536, S32_MIN, S32_MAX, 1000, 6554);
        push_item(5000, 0, 0, 65536, 0);
        push_item(-5500, 0, 0, 65536, 0);
        push_item(3000, 0, 0, -65536, 0);
        push_item(-3999, 0, 0, -65536, 0);
        push_item(2000, 0, 0, 0, 0);
        push_item(-3000, 0, 0, 0, 0);
        push_item(1500, 0, 0, 0, 0);
        wait_idle();
        write_reg(REG_STANDSTILL_BAND, 64'd1 << 20);
        push_random(250, 1'b0);
        wait_idle();

        // zero radius, then zero inverse inertia
        set_config(0, 70000, 24'hFF_FFFF, -13107200, 13107200, 655, 6554);
        push_random(40, 1'b0);
        wait_idle();
        set_config(40000, 0, 24'hFF_FFFF, -13107200, 13107200, 655, 6554);
        push_random(40, 1'b0);
        wait_idle();

        // random settings
        for (int pass = 0; pass < 4; pass++)
        begin
            calm   = (pass == 1);
            a      = $signed(rand_word());
            b      = $signed(rand_word());
            v_inv  = $urandom_range(1, 24'hFF_FFFF) >> $urandom_range(0, 20);
            if (v_inv == 0)
                v_inv = 1;
            v_dt   = $urandom_range(0, 24'hFF_FFFF) >> $urandom_range(0, 23);
            v_band = ($urandom() >> 1) >> $urandom_range(0, 30);
            v_vf   = ($urandom() >> 1) >> $urandom_range(0, 30);
            set_config($urandom_range(1, 65535), v_inv, v_dt,
                       (a < b) ? a : b, (a < b) ? b : a, v_band, v_vf);
            push_random(150, pass == 2);
            wait_idle();
        end

        repeat (80) @(negedge clk);
        if (mismatch_count == 0 && results_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
